>>> hw/rtl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared types and constants: button count, gesture state codes, the layout
// of one per-button memory entry and the event flags of one button.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int NUM_BUTTONS = 11;
   localparam int FIELD_W     = 11;
   localparam int CNT_W       = 4;
   localparam int LIMIT_W     = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int PAD_W       = (NUM_BUTTONS > FIELD_W) ? NUM_BUTTONS : FIELD_W;

   localparam logic [LIMIT_W-1:0] LONG_LIMIT_RESET = 4'd12;
   localparam logic [LIMIT_W-1:0] GAP_LIMIT_RESET  = 4'd8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT  = 1'b1;

   typedef enum logic [7:0] {
      GS_IDLE    = 8'b0000_0001,
      GS_DOWN1   = 8'b0000_0010,
      GS_UP1     = 8'b0000_0100,
      GS_DOWN2   = 8'b0000_1000,
      GS_CLICK   = 8'b0001_0000,
      GS_DCLICK  = 8'b0010_0000,
      GS_LONG    = 8'b0100_0000,
      GS_LONGUP  = 8'b1000_0000
   } gest_state_type;

   typedef struct packed {
      gest_state_type          state;
      logic [CNT_W-1:0]        count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type ENTRY_RESET = '{state: GS_IDLE, count: '0};

   // per-button events after one tick; click sits in bit 0
   typedef struct packed {
      logic second_press;
      logic first_press;
      logic long_release;
      logic long_hold;
      logic dclick;
      logic click;
   } event_type;

   localparam int EVT_N = $bits(event_type);

endpackage

>>> hw/rtl/bgd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bgd_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bgd_step.sv
// ----------------------------------------------------------------------------
// Gesture step
// Next state and hold count of one button for one tick, plus its event flags.
// ----------------------------------------------------------------------------
module bgd_step (
   input  bgd_pkg::entry_type                    cur,
   input  logic                                  pressed,
   input  logic [bgd_pkg::LIMIT_W-1:0]           long_limit,
   input  logic [bgd_pkg::LIMIT_W-1:0]           gap_limit,
   output bgd_pkg::entry_type                    nxt,
   output bgd_pkg::event_type                    evt
);
   import bgd_pkg::*;

   always_comb begin
      nxt = cur;
      case (cur.state)
         GS_IDLE: begin
            if (pressed) begin
               nxt.state = GS_DOWN1;
            end
         end
         GS_DOWN1, GS_DOWN2: begin
            if (cur.count > long_limit) begin
               nxt.state = GS_LONG;
               nxt.count = '0;
            end else if (pressed) begin
               nxt.count = cur.count + CNT_W'(1);
            end else begin
               nxt.state = (cur.state == GS_DOWN1) ? GS_UP1 : GS_DCLICK;
               nxt.count = '0;
            end
         end
         GS_UP1: begin
            if (cur.count > gap_limit) begin
               nxt.state = GS_CLICK;
               nxt.count = '0;
            end else if (!pressed) begin
               nxt.count = cur.count + CNT_W'(1);
            end else begin
               nxt.state = GS_DOWN2;
               nxt.count = '0;
            end
         end
         GS_LONG: begin
            if (!pressed) begin
               nxt.state = GS_LONGUP;
            end
         end
         default: begin
            // one-tick states fall back to idle
            nxt.state = GS_IDLE;
            nxt.count = '0;
         end
      endcase
   end

   always_comb begin
      evt.click        = (nxt.state == GS_CLICK);
      evt.dclick       = (nxt.state == GS_DCLICK);
      evt.long_hold    = (nxt.state == GS_LONG);
      evt.long_release = (nxt.state == GS_LONGUP);
      evt.first_press  = (nxt.state == GS_DOWN1) && (nxt.count == CNT_W'(1));
      evt.second_press = (nxt.state == GS_DOWN2) && (nxt.count == CNT_W'(1));
   end

endmodule

>>> hw/rtl/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// Button gesture detector
// A new req is accepted as the last entry of the previous sweep is read.
// The state memory is swept one entry a cycle while no finished result is
// held by rsp_stall; entries are read, then written back by the update stage.
// Reset: synchronous; limits return to 12 and 8, every button reads as idle
// with a zero count at once (per-entry valid bits, no clearing pass).
// ----------------------------------------------------------------------------
module button_gesture_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgd_pkg::LIMIT_W-1:0]       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bgd_pkg::FIELD_W-1:0]       req_button_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bgd_pkg::FIELD_W-1:0]       rsp_click_mask,
   output logic [bgd_pkg::FIELD_W-1:0]       rsp_dclick_mask,
   output logic [bgd_pkg::FIELD_W-1:0]       rsp_long_hold_mask,
   output logic [bgd_pkg::FIELD_W-1:0]       rsp_long_release_mask,
   output logic [bgd_pkg::FIELD_W-1:0]       rsp_first_press_mask,
   output logic [bgd_pkg::FIELD_W-1:0]       rsp_second_press_mask
);
   import bgd_pkg::*;

   // configuration
   logic [LIMIT_W-1:0] long_limit_ff, long_limit_in;
   logic [LIMIT_W-1:0] gap_limit_ff, gap_limit_in;

   // sweep (read issue) stage
   logic                   busy_ff, busy_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [NUM_BUTTONS-1:0] levels_ff, levels_in;

   // update (write back) stage
   logic                   s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]       s1_idx_ff, s1_idx_in;
   logic                   s1_level_ff, s1_level_in;
   logic                   s1_last_ff, s1_last_in;
   logic                   fwd_ff, fwd_in;
   entry_type              fwd_data_ff, fwd_data_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [NUM_BUTTONS-1:0] entry_vld_ff, entry_vld_in;

   logic [EVT_N-1:0][NUM_BUTTONS-1:0] acc_ff, acc_in;

   // result register
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [EVT_N-1:0][FIELD_W-1:0] rsp_mask_ff, rsp_mask_in;

   logic                   adv;
   logic                   issue;
   logic                   issue_last;
   logic                   accept;
   logic                   wr_en;
   logic [ENTRY_W-1:0]     ram_rdata;
   entry_type              cur_entry;
   entry_type              nxt_entry;
   event_type              evt;
   logic [EVT_N-1:0]       evt_bits;
   logic [PAD_W-1:0]       levels_pad;

   // hold both stages while a finished result cannot leave
   assign adv        = !(s1_vld_ff && s1_last_ff && rsp_vld_ff && rsp_stall);
   assign issue      = busy_ff && adv;
   assign issue_last = issue && (idx_ff == IDX_W'(NUM_BUTTONS - 1));
   assign req_stall  = !(adv && (!busy_ff || issue_last));
   assign accept     = req_valid && !req_stall;
   assign wr_en      = s1_vld_ff && adv;

   assign levels_pad = PAD_W'(req_button_levels);

   always_comb begin
      long_limit_in = long_limit_ff;
      gap_limit_in  = gap_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LONG_LIMIT: long_limit_in = csr_wr_data;
            CSR_GAP_LIMIT:  gap_limit_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      levels_in = levels_ff;
      if (accept) begin
         busy_in   = 1'b1;
         idx_in    = '0;
         levels_in = levels_pad[NUM_BUTTONS-1:0];
      end else if (issue_last) begin
         busy_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   bgd_ram #(
      .DEPTH (NUM_BUTTONS),
      .WIDTH (ENTRY_W)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (nxt_entry),
      .rd_en   (issue),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // forward the write when the same entry is read in that cycle
   always_comb begin
      if (fwd_ff) begin
         cur_entry = fwd_data_ff;
      end else if (rd_vld_ff) begin
         cur_entry = entry_type'(ram_rdata);
      end else begin
         cur_entry = ENTRY_RESET;
      end
   end

   bgd_step u_step (
      .cur        (cur_entry),
      .pressed    (s1_level_ff),
      .long_limit (long_limit_ff),
      .gap_limit  (gap_limit_ff),
      .nxt        (nxt_entry),
      .evt        (evt)
   );

   assign evt_bits = evt;

   always_comb begin
      s1_vld_in    = s1_vld_ff;
      s1_idx_in    = s1_idx_ff;
      s1_level_in  = s1_level_ff;
      s1_last_in   = s1_last_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      rd_vld_in    = rd_vld_ff;
      entry_vld_in = entry_vld_ff;
      if (adv) begin
         s1_vld_in   = issue;
         s1_idx_in   = idx_ff;
         s1_level_in = levels_ff[idx_ff];
         s1_last_in  = issue_last;
         fwd_in      = wr_en && issue && (s1_idx_ff == idx_ff);
         fwd_data_in = nxt_entry;
         rd_vld_in   = entry_vld_ff[idx_ff];
      end
      if (wr_en) begin
         entry_vld_in[s1_idx_ff] = 1'b1;
      end
   end

   // shift each event in from the top: after a full sweep bit i is button i
   always_comb begin
      acc_in = acc_ff;
      if (wr_en) begin
         for (int e = 0; e < EVT_N; e++) begin
            acc_in[e] = NUM_BUTTONS'({evt_bits[e], acc_ff[e]} >> 1);
         end
      end
   end

   always_comb begin
      logic [PAD_W-1:0] acc_pad;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_mask_in = rsp_mask_ff;
      acc_pad     = '0;
      if (wr_en && s1_last_ff) begin
         rsp_vld_in = 1'b1;
         for (int e = 0; e < EVT_N; e++) begin
            acc_pad        = PAD_W'(acc_in[e]);
            rsp_mask_in[e] = acc_pad[FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_limit_ff <= LONG_LIMIT_RESET;
         gap_limit_ff  <= GAP_LIMIT_RESET;
         busy_ff       <= 1'b0;
         idx_ff        <= '0;
         s1_vld_ff     <= 1'b0;
         s1_last_ff    <= 1'b0;
         fwd_ff        <= 1'b0;
         rd_vld_ff     <= 1'b0;
         entry_vld_ff  <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         long_limit_ff <= long_limit_in;
         gap_limit_ff  <= gap_limit_in;
         busy_ff       <= busy_in;
         idx_ff        <= idx_in;
         s1_vld_ff     <= s1_vld_in;
         s1_last_ff    <= s1_last_in;
         fwd_ff        <= fwd_in;
         rd_vld_ff     <= rd_vld_in;
         entry_vld_ff  <= entry_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff   <= levels_in;
      s1_idx_ff   <= s1_idx_in;
      s1_level_ff <= s1_level_in;
      fwd_data_ff <= fwd_data_in;
      acc_ff      <= acc_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid             = rsp_vld_ff;
   assign rsp_click_mask        = rsp_mask_ff[0];
   assign rsp_dclick_mask       = rsp_mask_ff[1];
   assign rsp_long_hold_mask    = rsp_mask_ff[2];
   assign rsp_long_release_mask = rsp_mask_ff[3];
   assign rsp_first_press_mask  = rsp_mask_ff[4];
   assign rsp_second_press_mask = rsp_mask_ff[5];

endmodule

>>> test/tb_button_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button gesture detector testbench
// Sends control ticks of button levels under random valid and stall gaps,
// predicts the six event masks of every tick from a per-button gesture model
// kept in the bench, and compares each transfer on the result side with the
// oldest prediction. Limits are changed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_button_gesture_detector;
   import bgd_pkg::*;

   localparam int LATENCY     = NUM_BUTTONS + 1;
   localparam int MAX_CYCLES  = 250000;
   localparam int HOLD_CYCLES = 300;

   // button groups for the directed sequence
   localparam logic [FIELD_W-1:0] GRP_A = 11'h007;
   localparam logic [FIELD_W-1:0] GRP_B = 11'h038;
   localparam logic [FIELD_W-1:0] GRP_C = 11'h1C0;
   localparam logic [FIELD_W-1:0] GRP_D = 11'h600;
   localparam logic [FIELD_W-1:0] ALL_BUTTONS = '1;

   typedef struct packed {
      logic [FIELD_W-1:0] click;
      logic [FIELD_W-1:0] dclick;
      logic [FIELD_W-1:0] long_hold;
      logic [FIELD_W-1:0] long_release;
      logic [FIELD_W-1:0] first_press;
      logic [FIELD_W-1:0] second_press;
   } gesture_masks_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]   csr_wr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [FIELD_W-1:0]   req_button_levels;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [FIELD_W-1:0]   rsp_click_mask;
   logic [FIELD_W-1:0]   rsp_dclick_mask;
   logic [FIELD_W-1:0]   rsp_long_hold_mask;
   logic [FIELD_W-1:0]   rsp_long_release_mask;
   logic [FIELD_W-1:0]   rsp_first_press_mask;
   logic [FIELD_W-1:0]   rsp_second_press_mask;

   // gesture model state and limits
   gest_state_type       btn_state [NUM_BUTTONS];
   logic [CNT_W-1:0]     btn_count [NUM_BUTTONS];
   logic [LIMIT_W-1:0]   long_limit;
   logic [LIMIT_W-1:0]   gap_limit;

   gesture_masks_type    pending_masks [$];

   int                   mismatch_count;
   int                   fail_count;
   int                   cycle_count;
   bit                   req_idle_en;
   bit                   rsp_idle_en;
   bit                   rsp_hold;
   bit                   hold_request;

   // press / release run lengths per button for the random ticks
   int unsigned          run_left [FIELD_W];
   logic [FIELD_W-1:0]   run_levels;

   button_gesture_detector DUT (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_button_levels     (req_button_levels),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_click_mask        (rsp_click_mask),
      .rsp_dclick_mask       (rsp_dclick_mask),
      .rsp_long_hold_mask    (rsp_long_hold_mask),
      .rsp_long_release_mask (rsp_long_release_mask),
      .rsp_first_press_mask  (rsp_first_press_mask),
      .rsp_second_press_mask (rsp_second_press_mask)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < MAX_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Advance every button by one tick and return the masks seen after it.
   function automatic gesture_masks_type advance_gestures(input logic [FIELD_W-1:0] levels);
      logic [PAD_W-1:0]  lv;
      logic [PAD_W-1:0]  m_click, m_dclick, m_long, m_longup, m_first, m_second;
      gest_state_type    s;
      logic [CNT_W-1:0]  c;
      gesture_masks_type res;
      lv = PAD_W'(levels);
      m_click  = '0;
      m_dclick = '0;
      m_long   = '0;
      m_longup = '0;
      m_first  = '0;
      m_second = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         s = btn_state[i];
         c = btn_count[i];
         case (s)
            GS_IDLE: begin
               if (lv[i]) s = GS_DOWN1;
            end
            GS_DOWN1, GS_DOWN2: begin
               if (c > long_limit) begin
                  s = GS_LONG;
                  c = '0;
               end else if (lv[i]) begin
                  c = c + 1'b1;
               end else begin
                  if (s == GS_DOWN1) s = GS_UP1;
                  else s = GS_DCLICK;
                  c = '0;
               end
            end
            GS_UP1: begin
               if (c > gap_limit) begin
                  s = GS_CLICK;
                  c = '0;
               end else if (!lv[i]) begin
                  c = c + 1'b1;
               end else begin
                  s = GS_DOWN2;
                  c = '0;
               end
            end
            GS_LONG: begin
               if (!lv[i]) s = GS_LONGUP;
            end
            default: begin
               s = GS_IDLE;
               c = '0;
            end
         endcase
         btn_state[i] = s;
         btn_count[i] = c;
         m_click[i]  = (s == GS_CLICK);
         m_dclick[i] = (s == GS_DCLICK);
         m_long[i]   = (s == GS_LONG);
         m_longup[i] = (s == GS_LONGUP);
         m_first[i]  = (s == GS_DOWN1) && (c == CNT_W'(1));
         m_second[i] = (s == GS_DOWN2) && (c == CNT_W'(1));
      end
      res.click        = m_click[FIELD_W-1:0];
      res.dclick       = m_dclick[FIELD_W-1:0];
      res.long_hold    = m_long[FIELD_W-1:0];
      res.long_release = m_longup[FIELD_W-1:0];
      res.first_press  = m_first[FIELD_W-1:0];
      res.second_press = m_second[FIELD_W-1:0];
      return res;
   endfunction

   // Mostly press/release runs sized around the current limits, some noise.
   function automatic logic [FIELD_W-1:0] next_levels();
      int unsigned pick;
      int unsigned lim;
      if ($urandom_range(0, 9) == 0) return FIELD_W'($urandom);
      for (int i = 0; i < FIELD_W; i++) begin
         if (run_left[i] == 0) begin
            run_levels[i] = ~run_levels[i];
            lim  = run_levels[i] ? long_limit : gap_limit;
            pick = $urandom_range(0, 9);
            if (pick < 5) run_left[i] = $urandom_range(1, 3);
            else if (pick < 8) run_left[i] = lim + $urandom_range(1, 3);
            else if (pick < 9) run_left[i] = $urandom_range(4, 12);
            else run_left[i] = $urandom_range(14, 20);
         end
         run_left[i]--;
      end
      return run_levels;
   endfunction

   // Offer one tick, hold it until the transfer, then predict its masks.
   task automatic send_tick(input logic [FIELD_W-1:0] levels);
      if (req_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_button_levels <= levels;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_masks.push_back(advance_gestures(levels));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_masks.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write both limits on back-to-back cycles; only while the block is idle.
   task automatic set_limits(input logic [LIMIT_W-1:0] long_val,
                             input logic [LIMIT_W-1:0] gap_val);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_LONG_LIMIT;
      csr_wr_data <= long_val;
      @(posedge clock);
      long_limit = long_val;
      @(negedge clock);
      csr_index   <= CSR_GAP_LIMIT;
      csr_wr_data <= gap_val;
      @(posedge clock);
      gap_limit = gap_val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int count, input bit allow_idle);
      for (int k = 0; k < count; k++) begin
         if (k % 30 == 0) begin
            req_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            rsp_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
         end
         send_tick(next_levels());
      end
   endtask

   task automatic compare_mask(input string field, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         if (mismatch_count < 10)
            $display("mismatch in %s at cycle %0d: expected %03h, got %03h",
                     field, cycle_count, want, got);
         mismatch_count++;
         fail_count++;
      end
   endtask

   // click, double click, long press and long release side by side
   task automatic test_directed_gestures();
      set_limits(4'd2, 4'd1);
      send_tick(GRP_A | GRP_B | GRP_C);
      send_tick(GRP_A | GRP_B | GRP_C);
      send_tick(GRP_C);
      send_tick(GRP_B | GRP_C);
      send_tick(GRP_B | GRP_C);
      send_tick(GRP_C);
      send_tick(GRP_D);
      send_tick('0);
      drain_results();
   endtask

   // limits of fifteen never fire; the hold count wraps past 15
   task automatic test_count_wrap();
      set_limits('1, '1);
      repeat (18) send_tick(ALL_BUTTONS);
      send_tick('0);
      send_tick(ALL_BUTTONS);
      drain_results();
   endtask

   task automatic test_random_limits();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_limits(LONG_LIMIT_RESET, GAP_LIMIT_RESET);
            1: set_limits('0, '0);
            2: set_limits('1, '1);
            3: set_limits(4'd14, 4'd14);
            4: set_limits(4'd1, 4'd0);
            5: set_limits(4'd0, 4'd15);
            default: set_limits(LIMIT_W'($urandom_range(0, 15)),
                                LIMIT_W'($urandom_range(0, 15)));
         endcase
         run_random(140, 1'b1);
         drain_results();
      end
   endtask

   // receiver holds off for a long stretch while ticks keep coming
   task automatic test_back_pressure();
      set_limits(4'd3, 4'd2);
      hold_request = 1'b1;
      run_random(40, 1'b0);
      drain_results();
   endtask

   task automatic test_full_rate();
      set_limits(LIMIT_W'($urandom_range(0, 15)), LIMIT_W'($urandom_range(0, 15)));
      run_random(250, 1'b0);
      drain_results();
   endtask

   initial begin : hold_ctl
      rsp_hold = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_hold     = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      end
   end

   initial begin : rsp_stall_gen
      int burst;
      burst     = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      gesture_masks_type got;
      gesture_masks_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_click_mask, rsp_dclick_mask, rsp_long_hold_mask,
                rsp_long_release_mask, rsp_first_press_mask, rsp_second_press_mask};
         if (pending_masks.size() == 0) begin
            if (mismatch_count < 10)
               $display("result transfer with nothing pending at cycle %0d", cycle_count);
            mismatch_count++;
            fail_count++;
         end else begin
            want = pending_masks.pop_front();
            compare_mask("click_mask", want.click, got.click);
            compare_mask("dclick_mask", want.dclick, got.dclick);
            compare_mask("long_hold_mask", want.long_hold, got.long_hold);
            compare_mask("long_release_mask", want.long_release, got.long_release);
            compare_mask("first_press_mask", want.first_press, got.first_press);
            compare_mask("second_press_mask", want.second_press, got.second_press);
         end
      end
   end

   initial begin : test_sequence
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_LONG_LIMIT;
      csr_wr_data       = '0;
      req_valid         = 1'b0;
      req_button_levels = '0;
      long_limit        = LONG_LIMIT_RESET;
      gap_limit         = GAP_LIMIT_RESET;
      mismatch_count    = 0;
      fail_count        = 0;
      req_idle_en       = 1'b1;
      rsp_idle_en       = 1'b1;
      hold_request      = 1'b0;
      run_levels        = '0;
      foreach (btn_state[i]) begin
         btn_state[i] = GS_IDLE;
         btn_count[i] = '0;
      end
      foreach (run_left[i]) run_left[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_gestures();
      test_count_wrap();
      test_random_limits();
      test_back_pressure();
      test_full_rate();

      // let any stray result show up before the verdict
      repeat (2 * LATENCY) @(posedge clock);
      if (fail_count == 0 && pending_masks.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bgd_pkg.sv
hw/rtl/bgd_ram.sv
hw/rtl/bgd_step.sv
hw/rtl/button_gesture_detector.sv
test/tb_button_gesture_detector.sv
